/* hw/rtl/lef_pkg.sv */
// Shared types and constants of the line editor escape filter.
package lef_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int ERASE_LEN   = 9;

    localparam logic [7:0] CAPACITY_RESET = 8'd32;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_CSI    = 8'h5B;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    // Echo sent for one backspace: cursor left, blank, cursor left.
    localparam logic [7:0] ERASE_SEQ [ERASE_LEN] = '{
        CH_ESC, CH_CSI, CH_ONE, CH_D, CH_SPACE, CH_ESC, CH_CSI, CH_ONE, CH_D
    };

    localparam logic [3:0] ERASE_LAST_STEP = 4'(ERASE_LEN - 1);

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_START,
        ESC_INTRO,
        ESC_PARAM
    } esc_phase_t;

    typedef enum logic [1:0] {
        CMD_ERROR,
        CMD_PRINT,
        CMD_ERASE,
        CMD_RETURN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] ch;
        logic [7:0] pos;
    } cmd_t;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic       write_valid;
        logic [7:0] write_index;
        logic [7:0] write_char;
        logic       line_done;
        logic [7:0] line_length;
        logic       escape_error;
        logic       run_last;
    } result_t;

endpackage

/* hw/rtl/lef_front.sv */
// Front end: escape phase tracking, cursor keeping and command issue.
module lef_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              queue_full,
    output logic              push,
    output lef_pkg::cmd_t     push_cmd
);

    lef_pkg::esc_phase_t phase_reg;
    lef_pkg::esc_phase_t phase_next;
    logic [7:0]          cursor_reg;
    logic [7:0]          cursor_next;
    logic [7:0]          capacity_reg;
    logic                accept;
    logic                is_esc;
    logic                is_intro;
    logic                is_param;
    logic                is_final;
    logic                in_seq;
    logic                malformed;
    logic                is_print;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        is_esc    = (in_byte == lef_pkg::CH_ESC);
        is_intro  = (phase_reg == lef_pkg::ESC_START) &&
                    (in_byte >= lef_pkg::CH_AT) && (in_byte <= lef_pkg::CH_UNDER);
        in_seq    = (phase_reg == lef_pkg::ESC_INTRO) || (phase_reg == lef_pkg::ESC_PARAM);
        is_param  = in_seq && (((in_byte >= lef_pkg::CH_ZERO) && (in_byte <= lef_pkg::CH_NINE))
                    || (in_byte == lef_pkg::CH_SEMI));
        is_final  = in_seq && (in_byte >= lef_pkg::CH_AT) && (in_byte <= lef_pkg::CH_TILDE);
        malformed = !is_esc && !is_intro && !is_param && !is_final &&
                    (phase_reg != lef_pkg::ESC_IDLE);
        is_print  = (in_byte >= lef_pkg::CH_SPACE) && (in_byte <= lef_pkg::CH_TILDE);
    end

    // Escape phase next state.
    always_comb
    begin
        phase_next = phase_reg;
        priority if (is_esc)
            phase_next = lef_pkg::ESC_START;
        else if (is_intro)
            phase_next = lef_pkg::ESC_INTRO;
        else if (is_param)
            phase_next = lef_pkg::ESC_PARAM;
        else
            phase_next = lef_pkg::ESC_IDLE;
    end

    // Command issue and cursor update; only bytes outside a sequence edit the line.
    always_comb
    begin
        push          = 1'b0;
        push_cmd.kind = lef_pkg::CMD_ERROR;
        push_cmd.ch   = in_byte;
        push_cmd.pos  = cursor_reg;
        cursor_next   = cursor_reg;
        priority if (is_esc || is_intro || is_param || is_final)
        begin
            push = 1'b0;
        end
        else if (malformed)
        begin
            push = accept;
        end
        else if (is_print)
        begin
            if (cursor_reg < capacity_reg)
            begin
                push          = accept;
                push_cmd.kind = lef_pkg::CMD_PRINT;
                cursor_next   = cursor_reg + 8'd1;
            end
        end
        else if (in_byte == lef_pkg::CH_DEL)
        begin
            if (cursor_reg != 8'd0)
            begin
                push          = accept;
                push_cmd.kind = lef_pkg::CMD_ERASE;
                cursor_next   = cursor_reg - 8'd1;
            end
        end
        else if (in_byte == lef_pkg::CH_CR)
        begin
            push          = accept;
            push_cmd.kind = lef_pkg::CMD_RETURN;
            cursor_next   = 8'd0;
        end
        else
        begin
            push = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= lef_pkg::ESC_IDLE;
            cursor_reg   <= 8'd0;
            capacity_reg <= lef_pkg::CAPACITY_RESET;
        end
        else
        begin
            if (accept)
            begin
                phase_reg  <= phase_next;
                cursor_reg <= cursor_next;
            end
            if (cfg_we)
                capacity_reg <= cfg_wdata;
        end
    end

endmodule

/* hw/rtl/lef_queue.sv */
// Short command queue between the front end and the result sequencer.
module lef_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lef_pkg::cmd_t     push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output lef_pkg::cmd_t     head
);

    lef_pkg::cmd_t                 mem [lef_pkg::QUEUE_DEPTH];
    logic [lef_pkg::QUEUE_AW-1:0]  wr_ptr_reg;
    logic [lef_pkg::QUEUE_AW-1:0]  rd_ptr_reg;
    logic [lef_pkg::QUEUE_AW:0]    count_reg;
    logic                          do_push;
    logic                          do_pop;

    assign full    = (count_reg == (lef_pkg::QUEUE_AW+1)'(lef_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* hw/rtl/lef_back.sv */
// Result sequencer: expands each queued command into its result requests.
module lef_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              queue_empty,
    input  lef_pkg::cmd_t     head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output lef_pkg::result_t  out_result
);

    logic [3:0]        step_reg;
    logic              out_valid_reg;
    lef_pkg::result_t  result_reg;
    lef_pkg::result_t  result_next;
    logic              load;

    assign load       = !queue_empty && (!out_valid_reg || out_ready);
    assign pop        = load && result_next.run_last;
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    always_comb
    begin
        result_next = '0;
        unique case (head.kind)
            lef_pkg::CMD_ERROR:
            begin
                result_next.escape_error = 1'b1;
                result_next.run_last     = 1'b1;
            end
            lef_pkg::CMD_PRINT:
            begin
                result_next.echo_valid  = 1'b1;
                result_next.echo_byte   = head.ch;
                result_next.write_valid = 1'b1;
                result_next.write_index = head.pos;
                result_next.write_char  = head.ch;
                result_next.run_last    = 1'b1;
            end
            lef_pkg::CMD_ERASE:
            begin
                result_next.echo_valid = 1'b1;
                result_next.echo_byte  = lef_pkg::ERASE_SEQ[step_reg];
                result_next.run_last   = (step_reg == lef_pkg::ERASE_LAST_STEP);
            end
            lef_pkg::CMD_RETURN:
            begin
                result_next.echo_valid = 1'b1;
                if (step_reg == 4'd0)
                begin
                    // Store the terminator while echoing the carriage return.
                    result_next.echo_byte   = lef_pkg::CH_CR;
                    result_next.write_valid = 1'b1;
                    result_next.write_index = head.pos;
                    result_next.write_char  = lef_pkg::CH_NUL;
                end
                else
                begin
                    result_next.echo_byte   = lef_pkg::CH_LF;
                    result_next.line_done   = 1'b1;
                    result_next.line_length = head.pos;
                    result_next.run_last    = 1'b1;
                end
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                step_reg      <= result_next.run_last ? 4'd0 : step_reg + 4'd1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* hw/rtl/line_editor_escape_filter_top.sv */
// Top level of the line editor escape filter.
// The first result request of a byte is offered once its command has passed the queue memory and the result register.
// Throughput: one byte per cycle is accepted while the four-entry command queue has room;
// the sequencer issues one result per cycle while the output is ready, so a backspace yields 9 results.
// Reset clears the cursor, the escape phase, the queue and the output; capacity returns to 32.
module line_editor_escape_filter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // echo_byte, write_index, write_char, line_length
    output logic [3:0]  m_axis_tuser,   // echo_valid, write_valid, line_done, escape_error
    output logic        m_axis_tlast    // run_last
);

    logic              push;
    lef_pkg::cmd_t     push_cmd;
    logic              queue_full;
    logic              queue_empty;
    logic              pop;
    lef_pkg::cmd_t     head;
    lef_pkg::result_t  result;

    lef_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    lef_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head     (head)
    );

    lef_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (result)
    );

    assign m_axis_tdata = {result.line_length, result.write_char,
                           result.write_index, result.echo_byte};
    assign m_axis_tuser = {result.escape_error, result.line_done,
                           result.write_valid, result.echo_valid};
    assign m_axis_tlast = result.run_last;

endmodule

/* verif/testbench.sv */
// Self-checking bench for the line editor escape filter: random byte streams, cursor model.
`timescale 1ns / 100ps

module testbench;
    import lef_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int RX_HOLD_CYCLES = 80;

    localparam logic [7:0] BEL = 8'h07;
    localparam logic [7:0] LOWER_X = 8'h78;
    localparam logic [7:0] UPPER_A = 8'h41;

    // Backspace echo: step left, overwrite with a blank, step left again.
    localparam logic [7:0] RUBOUT_ECHO [9] = '{
        CH_ESC, CH_CSI, CH_ONE, CH_D, CH_SPACE, CH_ESC, CH_CSI, CH_ONE, CH_D
    };

    localparam logic [7:0] OPENING [26] = '{
        CH_SPACE, CH_TILDE, CH_DEL, CH_DEL, CH_DEL, CH_CR,
        CH_ESC, CH_ESC, CH_AT, CH_ONE, CH_SEMI, CH_SEMI, CH_NINE, CH_TILDE,
        CH_ESC, CH_UNDER, BEL,
        CH_ESC, LOWER_X,
        CH_ESC, CH_CSI, CH_ZERO, CH_SPACE,
        CH_ESC, UPPER_A, CH_CR
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Predicted editor state.
    logic [7:0]  line_cap = CAPACITY_RESET;
    logic [7:0]  cursor = 8'h00;
    esc_phase_t  esc_state = ESC_IDLE;

    logic [7:0]  rx_bytes [$];
    result_t     line_events [$];
    int          mismatches = 0;

    bit          idle_en = 1'b0;
    int          tx_gap_left = 0;
    logic        tx_next_valid;
    int          rx_stall_left = 0;
    int          rx_hold_left = 0;
    int          rx_hold_start = 0;
    int          rx_hold_seen = 0;
    result_t     seen;
    result_t     want;

    line_editor_escape_filter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit is_param(input logic [7:0] b);
        return (b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI;
    endfunction

    function automatic result_t echo_of(input logic [7:0] b);
        result_t r;
        r = '0;
        r.echo_valid = 1'b1;
        r.echo_byte = b;
        return r;
    endfunction

    // Advances the editor state by one received byte and queues what it must produce.
    task automatic apply_terminal_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        if (b == CH_ESC)
        begin
            esc_state = ESC_START;
        end
        else if (esc_state == ESC_START && b >= CH_AT && b <= CH_UNDER)
        begin
            esc_state = ESC_INTRO;
        end
        else if ((esc_state == ESC_INTRO || esc_state == ESC_PARAM) && is_param(b))
        begin
            esc_state = ESC_PARAM;
        end
        else if ((esc_state == ESC_INTRO || esc_state == ESC_PARAM)
                 && b >= CH_AT && b <= CH_TILDE)
        begin
            esc_state = ESC_IDLE;
        end
        else if (esc_state != ESC_IDLE)
        begin
            // The byte that broke the sequence is swallowed.
            esc_state = ESC_IDLE;
            r.escape_error = 1'b1;
            r.run_last = 1'b1;
            line_events.push_back(r);
        end
        else if (b >= CH_SPACE && b <= CH_TILDE)
        begin
            if (cursor < line_cap)
            begin
                r = echo_of(b);
                r.write_valid = 1'b1;
                r.write_index = cursor;
                r.write_char = b;
                r.run_last = 1'b1;
                line_events.push_back(r);
                cursor = cursor + 8'd1;
            end
        end
        else if (b == CH_DEL)
        begin
            if (cursor != 8'h00)
            begin
                foreach (RUBOUT_ECHO[k])
                begin
                    r = echo_of(RUBOUT_ECHO[k]);
                    r.run_last = (k == 8);
                    line_events.push_back(r);
                end
                cursor = cursor - 8'd1;
            end
        end
        else if (b == CH_CR)
        begin
            r = echo_of(CH_CR);
            r.write_valid = 1'b1;
            r.write_index = cursor;
            r.write_char = CH_NUL;
            line_events.push_back(r);
            r = echo_of(CH_LF);
            r.line_done = 1'b1;
            r.line_length = cursor;
            r.run_last = 1'b1;
            line_events.push_back(r);
            cursor = 8'h00;
        end
    endtask

    // Sender: offers queued bytes, with random gaps only between requests.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            tx_gap_left = 0;
        end
        else
        begin
            tx_next_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_terminal_byte(s_axis_tdata);
                void'(rx_bytes.pop_front());
                tx_next_valid = 1'b0;
            end
            if (!tx_next_valid)
            begin
                if (tx_gap_left > 0)
                    tx_gap_left--;
                else if (idle_en && $urandom_range(0, 4) == 0)
                    tx_gap_left = $urandom_range(1, 4) - 1;
                else if (rx_bytes.size() > 0)
                begin
                    tx_next_valid = 1'b1;
                    s_axis_tdata <= rx_bytes[0];
                end
            end
            s_axis_tvalid <= tx_next_valid;
        end
    end

    // Receiver ready: short random stalls plus one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_stall_left = 0;
            rx_hold_left = 0;
        end
        else
        begin
            if (rx_hold_seen != rx_hold_start)
            begin
                rx_hold_seen = rx_hold_start;
                rx_hold_left = RX_HOLD_CYCLES;
            end
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_stall_left > 0)
            begin
                rx_stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                rx_stall_left = $urandom_range(1, 4) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen = '0;
            seen.echo_byte = m_axis_tdata[7:0];
            seen.write_index = m_axis_tdata[15:8];
            seen.write_char = m_axis_tdata[23:16];
            seen.line_length = m_axis_tdata[31:24];
            seen.echo_valid = m_axis_tuser[0];
            seen.write_valid = m_axis_tuser[1];
            seen.line_done = m_axis_tuser[2];
            seen.escape_error = m_axis_tuser[3];
            seen.run_last = m_axis_tlast;
            if (line_events.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, seen);
                mismatches++;
            end
            else
            begin
                want = line_events.pop_front();
                check_field("echo_valid", want.echo_valid, seen.echo_valid);
                check_field("echo_byte", want.echo_byte, seen.echo_byte);
                check_field("write_valid", want.write_valid, seen.write_valid);
                check_field("write_index", want.write_index, seen.write_index);
                check_field("write_char", want.write_char, seen.write_char);
                check_field("line_done", want.line_done, seen.line_done);
                check_field("line_length", want.line_length, seen.line_length);
                check_field("escape_error", want.escape_error, seen.escape_error);
                check_field("run_last", want.run_last, seen.run_last);
            end
        end
    end

    // Returns once every byte is accepted, every result has come and the pipe has settled.
    task automatic wait_drained();
        while (rx_bytes.size() > 0 || line_events.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [7:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        line_cap = value;
        @(negedge clk);
    endtask

    task automatic push_params();
        int n;
        n = $urandom_range(0, 4);
        repeat (n)
            rx_bytes.push_back(($urandom_range(0, 5) == 0) ? CH_SEMI
                               : 8'($urandom_range(CH_ZERO, CH_NINE)));
    endtask

    // Mostly well-formed typing and escape sequences, with some broken ones and noise.
    task automatic queue_terminal_traffic(input int count);
        int start;
        int pick;
        int depth;
        logic [7:0] b;
        bit ok;
        start = rx_bytes.size();
        while (rx_bytes.size() - start < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                rx_bytes.push_back(8'($urandom_range(CH_SPACE, CH_TILDE)));
            else if (pick < 55)
                rx_bytes.push_back(CH_DEL);
            else if (pick < 62)
                rx_bytes.push_back(CH_CR);
            else if (pick < 80)
            begin
                rx_bytes.push_back(CH_ESC);
                rx_bytes.push_back(($urandom_range(0, 2) == 0)
                                   ? 8'($urandom_range(CH_AT, CH_UNDER)) : CH_CSI);
                push_params();
                rx_bytes.push_back(8'($urandom_range(CH_AT, CH_TILDE)));
            end
            else if (pick < 90)
            begin
                depth = $urandom_range(0, 2);
                rx_bytes.push_back(CH_ESC);
                if (depth >= 1)
                    rx_bytes.push_back(CH_CSI);
                if (depth == 2)
                    push_params();
                do
                begin
                    b = 8'($urandom_range(0, 255));
                    ok = (b != CH_ESC) && ((depth == 0)
                         ? !(b >= CH_AT && b <= CH_UNDER)
                         : !(is_param(b) || (b >= CH_AT && b <= CH_TILDE)));
                end
                while (!ok);
                rx_bytes.push_back(b);
            end
            else
                rx_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (4) @(negedge clk);

        foreach (OPENING[i])
            rx_bytes.push_back(OPENING[i]);
        wait_drained();

        idle_en = 1'b1;
        write_capacity(8'd0);
        queue_terminal_traffic(30);
        wait_drained();

        // Fill part of a long line, then shrink the capacity below the cursor.
        write_capacity(8'd255);
        repeat (10)
            rx_bytes.push_back(8'($urandom_range(CH_SPACE, CH_TILDE)));
        wait_drained();
        write_capacity(8'd3);
        queue_terminal_traffic(20);
        wait_drained();

        write_capacity(8'd1);
        queue_terminal_traffic(40);
        wait_drained();

        // The receiver stops for a long while so the input side must back up.
        write_capacity(8'd8);
        rx_hold_start++;
        queue_terminal_traffic(60);
        wait_drained();

        write_capacity(8'd255);
        queue_terminal_traffic(80);
        wait_drained();

        idle_en = 1'b0;
        write_capacity(8'd32);
        queue_terminal_traffic(60);
        wait_drained();

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
